/* src/scba_pkg.sv */
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, constants and class selection for the block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam int DEF_NUM_PAGES  = 64;
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int NUM_CLASSES    = 9;
  localparam int CLS_W          = 4;
  localparam int LIST_W         = 9;
  localparam int ADDR_W         = 18;
  localparam int LEN_W          = 16;
  localparam int GRAN_W         = 8;
  localparam logic [LIST_W-1:0] LIST_NIL = 9'd256;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_PAGE   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic             ok;
    logic [CLS_W-1:0] cls;
  } class_sel_t;

  function automatic class_sel_t pick_class(input logic [LEN_W-1:0] len);
    class_sel_t r;
    r.ok  = (len <= 16'd4096);
    r.cls = 4'd8;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if ({1'b0, len} <= (17'd16 << k)) begin
        r.cls = CLS_W'(k);
      end
    end
    return r;
  endfunction

endpackage

/* src/scba_ram.sv */
// ----------------------------------------------------------------------------
// scba_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/size_class_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit
// Size-class block allocator over a pool of pages.
//
// Input stream: in_tuser carries the opcode (allocate or free), in_tdata the
// request length and, for a free, the block address. One result transfer
// follows every input transfer: status and granted address on out_tdata.
// Lengths up to 4096 bytes map onto classes of 16 to 4096 bytes.
// Steps from the input transfer to the result register: a rejected length
// goes straight there; an allocate or a free walks its class chain through
// the page table, one page per hop, and a free unlinks a released page
// behind its predecessor; a fresh page is found by scanning the page table
// for a free one, then carving its (256 >> class) blocks into the link
// list. The next transfer is taken in the cycle after the result register
// loads. The page table RAM port is visited once per hop.
// One item is in work at a time; the result sits in an output register, so
// the next item is taken while the receiver stalls, and the block waits only
// when a second result is ready before the first is taken.
// Reset: a sweep over the page table marks every page free; in_tready stays
// low until it ends. Block link RAM is not cleared.
// ----------------------------------------------------------------------------
module size_class_block_allocator_unit
  import scba_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [15:0] request_length, [33:16] block_address
  input  logic [0:0]  in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] status, [19:2] granted_address
);

  localparam int PIW  = $clog2(NUM_PAGES);
  localparam int PW   = $clog2(NUM_PAGES + 1);
  localparam int CW   = (PW > 6) ? PW : 6;
  localparam int LDEP = NUM_PAGES * 256;
  localparam int LAW  = $clog2(LDEP);
  localparam logic [PW-1:0] CHAIN_NIL = PW'(NUM_PAGES);

  typedef struct packed {
    logic              in_use;
    logic [CLS_W-1:0]  cls;
    logic [PW-1:0]     nxt;
    logic [LIST_W-1:0] fhead;
    logic [LIST_W-1:0] cnt;
  } pent_t;

  localparam int PENT_W = $bits(pent_t);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_WREQ   = 11'b00000000100,
    S_WCHK   = 11'b00000001000,
    S_POP    = 11'b00000010000,
    S_UNLINK = 11'b00000100000,
    S_SREQ   = 11'b00001000000,
    S_SCHK   = 11'b00010000000,
    S_CARVE  = 11'b00100000000,
    S_NEWPG  = 11'b01000000000,
    S_RESP   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [PW-1:0] head_r [NUM_CLASSES];
  logic [PW-1:0] head_wdata;
  logic head_we;

  logic             op_r, op_nxt;
  logic [CLS_W-1:0] c_r, c_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [PW-1:0] p_r, p_nxt, prev_r, prev_nxt, steps_r, steps_nxt, nlink_r, nlink_nxt;
  logic [PIW-1:0] q_r, q_nxt;
  logic [GRAN_W-1:0] i_r, i_nxt;
  pent_t cur_r, cur_nxt, prev_ent_r, prev_ent_nxt;
  status_t res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic pt_we;
  logic [PIW-1:0] pt_waddr, pt_raddr;
  pent_t pt_wdata, pt_rdata;
  logic [PENT_W-1:0] pt_rdata_raw;
  logic lk_we;
  logic [LAW-1:0] lk_waddr, lk_raddr;
  logic [LIST_W-1:0] lk_wdata, lk_rdata;

  class_sel_t in_sel;
  logic [LEN_W-1:0] in_len;
  logic [PW-1:0] in_head, hop_next, steps_inc;
  logic [LIST_W-1:0] n_blk, dec_cnt;
  logic [GRAN_W-1:0] free_blk, pop_blk;
  logic hop_end;

  assign pt_rdata = pent_t'(pt_rdata_raw);

  scba_ram #(.WIDTH(PENT_W), .DEPTH(NUM_PAGES)) u_page_ram (
    .clk  (clk),
    .we   (pt_we),
    .waddr(pt_waddr),
    .wdata(pt_wdata),
    .raddr(pt_raddr),
    .rdata(pt_rdata_raw)
  );

  scba_ram #(.WIDTH(LIST_W), .DEPTH(LDEP)) u_link_ram (
    .clk  (clk),
    .we   (lk_we),
    .waddr(lk_waddr),
    .wdata(lk_wdata),
    .raddr(lk_raddr),
    .rdata(lk_rdata)
  );

  assign in_len    = in_tdata[15:0];
  assign in_sel    = pick_class(in_len);
  assign in_head   = head_r[in_sel.cls];
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_addr_r, out_status_r};

  assign n_blk     = LIST_NIL >> c_r;
  assign hop_next  = pt_rdata.nxt;
  assign steps_inc = steps_r + PW'(1);
  assign hop_end   = (hop_next >= CHAIN_NIL) || (steps_inc >= CHAIN_NIL);
  assign free_blk  = GRAN_W'(addr_r[11:0] >> (c_r + CLS_W'(4)));
  assign pop_blk   = cur_r.fhead[GRAN_W-1:0];
  assign dec_cnt   = (pt_rdata.cnt != '0) ? pt_rdata.cnt - LIST_W'(1) : '0;
  assign pt_raddr  = (state_r == S_SREQ) ? q_r : p_r[PIW-1:0];
  assign lk_raddr  = {p_r[PIW-1:0], GRAN_W'(pt_rdata.fhead[GRAN_W-1:0] << c_r)};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    c_nxt          = c_r;
    addr_nxt       = addr_r;
    p_nxt          = p_r;
    prev_nxt       = prev_r;
    steps_nxt      = steps_r;
    nlink_nxt      = nlink_r;
    q_nxt          = q_r;
    i_nxt          = i_r;
    cur_nxt        = cur_r;
    prev_ent_nxt   = prev_ent_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    pt_we          = 1'b0;
    pt_waddr       = p_r[PIW-1:0];
    pt_wdata       = pt_rdata;
    lk_we          = 1'b0;
    lk_waddr       = {p_r[PIW-1:0], GRAN_W'(free_blk << c_r)};
    lk_wdata       = pt_rdata.fhead;
    head_we        = 1'b0;
    head_wdata     = hop_next;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = q_r;
        pt_wdata = '0;
        q_nxt    = q_r + PIW'(1);
        if (q_r == PIW'(NUM_PAGES - 1)) begin
          q_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_tuser[0];
          c_nxt        = in_sel.cls;
          addr_nxt     = in_tdata[33:16];
          p_nxt        = in_head;
          prev_nxt     = CHAIN_NIL;
          steps_nxt    = '0;
          q_nxt        = '0;
          res_addr_nxt = '0;
          if (!in_sel.ok) begin
            res_status_nxt = ST_TOO_LARGE;
            state_nxt      = S_RESP;
          end else if (in_head >= CHAIN_NIL) begin
            if (in_tuser[0] == OP_ALLOC) begin
              state_nxt = S_SREQ;
            end else begin
              res_status_nxt = ST_NOT_FOUND;
              state_nxt      = S_RESP;
            end
          end else begin
            state_nxt = S_WREQ;
          end
        end
      end
      S_WREQ: begin
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        cur_nxt = pt_rdata;
        if (op_r == OP_ALLOC && pt_rdata.fhead != LIST_NIL) begin
          state_nxt = S_POP;
        end else if (op_r == OP_FREE && CW'(p_r) == CW'(addr_r[17:12])) begin
          lk_we          = 1'b1;
          pt_we          = 1'b1;
          pt_wdata.fhead = LIST_W'(free_blk);
          pt_wdata.cnt   = dec_cnt;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
          if (dec_cnt == '0) begin
            pt_wdata.in_use = 1'b0;
            if (prev_r >= CHAIN_NIL) begin
              head_we = 1'b1;
            end else begin
              nlink_nxt = hop_next;
              state_nxt = S_UNLINK;
            end
          end
        end else begin
          prev_nxt     = p_r;
          prev_ent_nxt = pt_rdata;
          p_nxt        = hop_next;
          steps_nxt    = steps_inc;
          if (!hop_end) begin
            state_nxt = S_WREQ;
          end else if (op_r == OP_ALLOC) begin
            state_nxt = S_SREQ;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_RESP;
          end
        end
      end
      S_POP: begin
        pt_we          = 1'b1;
        pt_wdata       = cur_r;
        pt_wdata.fhead = lk_rdata;
        pt_wdata.cnt   = cur_r.cnt + LIST_W'(1);
        res_status_nxt = ST_OK;
        res_addr_nxt   = (ADDR_W'(p_r) << 12) + (ADDR_W'({pop_blk, 4'd0}) << c_r);
        state_nxt      = S_RESP;
      end
      S_UNLINK: begin
        pt_we        = 1'b1;
        pt_waddr     = prev_r[PIW-1:0];
        pt_wdata     = prev_ent_r;
        pt_wdata.nxt = nlink_r;
        state_nxt    = S_RESP;
      end
      S_SREQ: begin
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (!pt_rdata.in_use) begin
          p_nxt     = PW'(q_r);
          i_nxt     = '0;
          state_nxt = S_CARVE;
        end else if (q_r == PIW'(NUM_PAGES - 1)) begin
          res_status_nxt = ST_NO_PAGE;
          state_nxt      = S_RESP;
        end else begin
          q_nxt     = q_r + PIW'(1);
          state_nxt = S_SREQ;
        end
      end
      S_CARVE: begin
        lk_we    = 1'b1;
        lk_waddr = {p_r[PIW-1:0], GRAN_W'(i_r << c_r)};
        if (LIST_W'(i_r) == n_blk - LIST_W'(1)) begin
          lk_wdata  = LIST_NIL;
          state_nxt = S_NEWPG;
        end else begin
          lk_wdata = LIST_W'(i_r) + LIST_W'(1);
          i_nxt    = i_r + GRAN_W'(1);
        end
      end
      S_NEWPG: begin
        pt_we           = 1'b1;
        pt_wdata.in_use = 1'b1;
        pt_wdata.cls    = c_r;
        pt_wdata.nxt    = head_r[c_r];
        pt_wdata.fhead  = (n_blk > LIST_W'(1)) ? LIST_W'(1) : LIST_NIL;
        pt_wdata.cnt    = LIST_W'(1);
        head_we         = 1'b1;
        head_wdata      = p_r;
        res_status_nxt  = ST_OK;
        res_addr_nxt    = ADDR_W'(p_r) << 12;
        state_nxt       = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      q_r         <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        head_r[k] <= CHAIN_NIL;
      end
    end else begin
      state_r     <= state_nxt;
      q_r         <= q_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_we) begin
        head_r[c_r] <= head_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    c_r          <= c_nxt;
    addr_r       <= addr_nxt;
    p_r          <= p_nxt;
    prev_r       <= prev_nxt;
    steps_r      <= steps_nxt;
    nlink_r      <= nlink_nxt;
    i_r          <= i_nxt;
    cur_r        <= cur_nxt;
    prev_ent_r   <= prev_ent_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  a_addr_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[19:2] == '0)
    else $error("granted address set on a failed request");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WREQ |-> p_r < CHAIN_NIL)
    else $error("page walk beyond the pool");

  a_carve_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CARVE |-> LIST_W'(i_r) < n_blk)
    else $error("carve index past the page");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_tready)
    else $error("transfer accepted during reset sweep");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != S_IDLE)
    else $error("accepted item produced no work");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free requests into the size class block allocator.
// A scoreboard keeps its own copy of the page pool and works out each
// expected status and address. Received results are checked in order.
// The sender works in bursts with gaps. The receiver stalls in several
// patterns and once holds off for a long stretch. The random part mixes
// frees of live blocks with bad lengths, stray addresses and double frees.
// ----------------------------------------------------------------------------
module testbench;
  import scba_pkg::*;

  localparam int PAGES      = DEF_NUM_PAGES;
  localparam int CHAIN_END  = PAGES;
  localparam int LINK_END   = 256;
  localparam int RAND_ITEMS = 930;
  localparam int MAX_CYCLES = 1500000;

  typedef struct {
    status_t          st;
    logic [ADDR_W-1:0] addr;
  } grant_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } live_block_t;

  class alloc_scoreboard;
    int unsigned chain_head[NUM_CLASSES];
    bit          page_busy[PAGES];
    int unsigned chain_next[PAGES];
    int unsigned free_head[PAGES];
    int unsigned live_count[PAGES];
    int unsigned blk_link[PAGES*256];
    grant_t      pending_q[$];
    int          errors;

    function new();
      foreach (chain_head[c]) chain_head[c] = CHAIN_END;
      foreach (page_busy[p]) page_busy[p] = 0;
      errors = 0;
    endfunction

    function int unsigned link_at(int unsigned p, int unsigned blk, int unsigned c);
      return p * 256 + ((blk << c) & 255);
    endfunction

    function grant_t grant_block(int unsigned c);
      grant_t      g;
      int unsigned p, steps, q, n, blk;
      g.st = ST_OK;
      g.addr = '0;
      p = chain_head[c];
      steps = 0;
      while (p < PAGES && steps < PAGES && free_head[p] == LINK_END) begin
        p = chain_next[p];
        steps++;
      end
      if (p >= PAGES || steps >= PAGES) begin
        for (q = 0; q < PAGES; q++) if (!page_busy[q]) break;
        if (q >= PAGES) begin
          g.st = ST_NO_PAGE;
          return g;
        end
        p = q;
        n = 256 >> c;
        for (int unsigned i = 0; i < n; i++)
          blk_link[link_at(p, i, c)] = (i + 1 < n) ? i + 1 : LINK_END;
        page_busy[p] = 1;
        free_head[p] = 0;
        live_count[p] = 0;
        chain_next[p] = chain_head[c];
        chain_head[c] = p;
      end
      blk = free_head[p] & 255;
      free_head[p] = blk_link[link_at(p, blk, c)];
      live_count[p] = (live_count[p] + 1) & 511;
      g.addr = ADDR_W'(p * 4096 + (blk << (4 + c)));
      return g;
    endfunction

    function grant_t release_block(int unsigned c, logic [ADDR_W-1:0] addr);
      grant_t      g;
      int unsigned p, prev, steps, blk;
      g.st = ST_OK;
      g.addr = '0;
      p = chain_head[c];
      prev = CHAIN_END;
      steps = 0;
      while (p < PAGES && steps < PAGES && p != addr[17:12]) begin
        prev = p;
        p = chain_next[p];
        steps++;
      end
      if (p >= PAGES || steps >= PAGES) begin
        g.st = ST_NOT_FOUND;
        return g;
      end
      blk = addr[11:0] >> (4 + c);
      blk_link[link_at(p, blk, c)] = free_head[p];
      free_head[p] = blk;
      if (live_count[p] > 0) live_count[p]--;
      if (live_count[p] == 0) begin
        if (prev >= PAGES) chain_head[c] = chain_next[p];
        else chain_next[prev] = chain_next[p];
        page_busy[p] = 0;
      end
      return g;
    endfunction

    function grant_t note_request(opcode_t op, logic [LEN_W-1:0] len,
                                  logic [ADDR_W-1:0] addr);
      grant_t      g;
      int unsigned c;
      c = 0;
      while (c < NUM_CLASSES - 1 && (16 << c) < len) c++;
      if (len > 4096) begin
        g.st = ST_TOO_LARGE;
        g.addr = '0;
      end else if (op == OP_ALLOC) begin
        g = grant_block(c);
      end else begin
        g = release_block(c, addr);
      end
      pending_q.push_back(g);
      return g;
    endfunction

    function void check_result(logic [23:0] data);
      grant_t g;
      if (pending_q.size() == 0) begin
        $error("result with no request waiting: %h", data);
        errors++;
        return;
      end
      g = pending_q.pop_front();
      if (data[1:0] !== g.st) begin
        $error("status: expected %0d, actual %0d", g.st, data[1:0]);
        errors++;
      end
      if (data[19:2] !== g.addr) begin
        $error("granted_address: expected %h, actual %h", g.addr, data[19:2]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;

  alloc_scoreboard sb = new();
  live_block_t     live_q[$];
  int              accepted = 0;
  int              burst_left = 0;
  longint          cycles = 0;

  size_class_block_allocator_unit dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: switches among four ready patterns, one of them always ready; one long hold-off
  initial begin
    int mode, hold_left;
    bit held;
    mode = 0;
    hold_left = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (!held && accepted >= 300) begin
        held = 1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((cycles % 7) < 4);
        endcase
      end
    end
  end

  task automatic send(opcode_t op, logic [LEN_W-1:0] len, logic [ADDR_W-1:0] addr);
    grant_t g;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'b0, addr, len};
    do @(posedge clk); while (!in_tready);
    g = sb.note_request(op, len, addr);
    accepted++;
    if (op == OP_ALLOC && g.st == ST_OK) live_q.push_back('{g.addr, len});
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic free_live(bit unaligned, bit keep);
    live_block_t b;
    int          k;
    k = $urandom_range(0, live_q.size() - 1);
    b = live_q[k];
    if (!keep) live_q.delete(k);
    send(OP_FREE, b.len,
         unaligned ? ADDR_W'(b.addr + $urandom_range(0, 15)) : b.addr);
  endtask

  function automatic logic [LEN_W-1:0] random_len(bit big);
    int c;
    c = big ? $urandom_range(4, 8) : $urandom_range(0, 4);
    return LEN_W'((c == 0) ? $urandom_range(0, 16)
                           : $urandom_range((8 << c) + 1, 16 << c));
  endfunction

  initial begin
    int  r;
    bit  alloc_phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send(OP_ALLOC, 16'd0, '0);
    send(OP_ALLOC, 16'd1, 18'h3ffff);
    send(OP_ALLOC, 16'd16, '0);
    send(OP_ALLOC, 16'd17, '0);
    send(OP_ALLOC, 16'd4096, '0);
    send(OP_ALLOC, 16'd4097, '0);
    send(OP_ALLOC, 16'hffff, '0);
    send(OP_FREE, 16'hffff, 18'h3ffff);
    send(OP_FREE, 16'd64, 18'h3f000);
    send(OP_FREE, live_q[4].len, live_q[4].addr);
    send(OP_FREE, live_q[3].len, ADDR_W'(live_q[3].addr + 5));
    send(OP_FREE, live_q[0].len, live_q[0].addr);
    send(OP_FREE, live_q[0].len, live_q[0].addr);
    send(OP_ALLOC, 16'd2048, '0);
    send(OP_ALLOC, 16'd256, '0);
    live_q.delete();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 600) begin
        in_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
      alloc_phase = ((i / 120) % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send(opcode_t'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 16'hffff)),
             ADDR_W'($urandom_range(0, 18'h3ffff)));
      end else if (r < 12 && live_q.size() > 0) begin
        free_live(0, 1);
      end else if ((alloc_phase ? r < 80 : r < 35) || live_q.size() == 0) begin
        send(OP_ALLOC, random_len($urandom_range(0, 4) == 0),
             ADDR_W'($urandom_range(0, 18'h3ffff)));
      end else begin
        free_live($urandom_range(0, 3) == 0, 0);
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* size_class_block_allocator_unit.f */
src/scba_pkg.sv
src/scba_ram.sv
src/size_class_block_allocator_unit.sv
bench/testbench.sv
